// ===== src/piecewise_linear_contrast_stretch_top_defines.svh =====
// assertion helpers shared by the block
`ifndef PIECEWISE_LINEAR_CONTRAST_STRETCH_TOP_DEFINES_SVH
`define PIECEWISE_LINEAR_CONTRAST_STRETCH_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PLCS_ASSERT_IMPLY(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (lhs) |-> (rhs)) \
        else $error("plcs: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define PLCS_ASSERT_NEXT(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (lhs) |=> (rhs)) \
        else $error("plcs: next-cycle check failed");

`endif

// ===== src/plcs_pkg.sv =====
package plcs_pkg;

    localparam int PIX_W = 8;
    localparam int SEG_W = 2;
    localparam int IDX_W = 2;
    localparam int PROD_W = 2 * PIX_W;
    localparam int DIV_BITS_PER_STAGE = 2;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    // register indexes
    localparam logic [IDX_W-1:0] REG_LOW_BREAK  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HIGH_BREAK = 2'd1;
    localparam logic [IDX_W-1:0] REG_LOW_LEVEL  = 2'd2;
    localparam logic [IDX_W-1:0] REG_HIGH_LEVEL = 2'd3;

    localparam logic [PIX_W-1:0] RST_LOW_BREAK  = 8'd64;
    localparam logic [PIX_W-1:0] RST_HIGH_BREAK = 8'd192;
    localparam logic [PIX_W-1:0] RST_LOW_LEVEL  = 8'd32;
    localparam logic [PIX_W-1:0] RST_HIGH_LEVEL = 8'd224;

    // segment codes
    localparam logic [SEG_W-1:0] SEG_LOW  = 2'd0;
    localparam logic [SEG_W-1:0] SEG_MID  = 2'd1;
    localparam logic [SEG_W-1:0] SEG_HIGH = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0] low_break;
        logic [PIX_W-1:0] high_break;
        logic [PIX_W-1:0] low_level;
        logic [PIX_W-1:0] high_level;
    } cfg_t;

    // fields that ride along with the arithmetic
    typedef struct packed {
        logic [PIX_W-1:0] divisor;
        logic [PIX_W-1:0] offset;
        logic             neg;
        logic [SEG_W-1:0] segment;
        logic             degenerate;
    } side_t;

    typedef struct packed {
        logic [PIX_W-1:0] mul_a;
        logic [PIX_W-1:0] mul_b;
        side_t            side;
    } setup_t;

    // rem holds the partial remainder, work the unused dividend bits
    // on top of the quotient bits shifted in so far
    typedef struct packed {
        logic [PIX_W-1:0] rem;
        logic [PIX_W-1:0] work;
        side_t            side;
    } div_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic [SEG_W-1:0] segment;
        logic             degenerate;
    } result_t;

endpackage

// ===== src/plcs_setup.sv =====
module plcs_setup (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [plcs_pkg::PIX_W-1:0]    pixel_in,
    input  plcs_pkg::cfg_t                cfg,
    output plcs_pkg::setup_t              setup_out
);

    plcs_pkg::setup_t setup_reg;
    plcs_pkg::setup_t setup_next;

    always_comb begin
        setup_next = '0;
        if (pixel_in < cfg.low_break) begin
            setup_next.mul_a           = pixel_in;
            setup_next.mul_b           = cfg.low_level;
            setup_next.side.divisor    = cfg.low_break;
            setup_next.side.offset     = '0;
            setup_next.side.segment    = plcs_pkg::SEG_LOW;
        end else if (pixel_in > cfg.high_break) begin
            setup_next.mul_a           = pixel_in - cfg.high_break;
            setup_next.mul_b           = plcs_pkg::PIX_MAX - cfg.high_level;
            setup_next.side.divisor    = plcs_pkg::PIX_MAX - cfg.high_break;
            setup_next.side.offset     = cfg.high_level;
            setup_next.side.segment    = plcs_pkg::SEG_HIGH;
        end else if (cfg.low_break == cfg.high_break) begin
            // zero-width middle segment: quotient forced to zero
            setup_next.mul_a           = '0;
            setup_next.mul_b           = '0;
            setup_next.side.divisor    = {{(plcs_pkg::PIX_W-1){1'b0}}, 1'b1};
            setup_next.side.offset     = cfg.low_level;
            setup_next.side.segment    = plcs_pkg::SEG_MID;
            setup_next.side.degenerate = 1'b1;
        end else begin
            setup_next.mul_a           = pixel_in - cfg.low_break;
            setup_next.side.divisor    = cfg.high_break - cfg.low_break;
            setup_next.side.offset     = cfg.low_level;
            setup_next.side.segment    = plcs_pkg::SEG_MID;
            // falling segment: divide the magnitude, negate at the end
            if (cfg.high_level >= cfg.low_level) begin
                setup_next.mul_b    = cfg.high_level - cfg.low_level;
            end else begin
                setup_next.mul_b    = cfg.low_level - cfg.high_level;
                setup_next.side.neg = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            setup_reg <= setup_next;
        end
    end

    assign setup_out = setup_reg;

endmodule

// ===== src/plcs_mult.sv =====
module plcs_mult (
    input  logic              aclk,
    input  logic              en,
    input  plcs_pkg::setup_t  setup_in,
    output plcs_pkg::div_t    div_out
);

    plcs_pkg::div_t               div_reg;
    plcs_pkg::div_t               div_next;
    logic [plcs_pkg::PROD_W-1:0]  product;

    always_comb begin
        product       = setup_in.mul_a * setup_in.mul_b;
        // product < divisor * 256, so the top byte is already below the divisor
        div_next.rem  = product[plcs_pkg::PROD_W-1:plcs_pkg::PIX_W];
        div_next.work = product[plcs_pkg::PIX_W-1:0];
        div_next.side = setup_in.side;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg <= div_next;
        end
    end

    assign div_out = div_reg;

endmodule

// ===== src/plcs_div_step.sv =====
module plcs_div_step (
    input  logic            aclk,
    input  logic            en,
    input  plcs_pkg::div_t  div_in,
    output plcs_pkg::div_t  div_out
);

    plcs_pkg::div_t div_reg;
    plcs_pkg::div_t div_next;

    always_comb begin
        logic [plcs_pkg::PIX_W:0]   trial;
        logic [plcs_pkg::PIX_W-1:0] rem;
        logic [plcs_pkg::PIX_W-1:0] work;
        logic                       qbit;
        rem  = div_in.rem;
        work = div_in.work;
        for (int i = 0; i < plcs_pkg::DIV_BITS_PER_STAGE; i++) begin
            trial = {rem, work[plcs_pkg::PIX_W-1]};
            if (trial >= {1'b0, div_in.side.divisor}) begin
                trial = trial - {1'b0, div_in.side.divisor};
                qbit  = 1'b1;
            end else begin
                qbit  = 1'b0;
            end
            rem  = trial[plcs_pkg::PIX_W-1:0];
            work = {work[plcs_pkg::PIX_W-2:0], qbit};
        end
        div_next.rem  = rem;
        div_next.work = work;
        div_next.side = div_in.side;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg <= div_next;
        end
    end

    assign div_out = div_reg;

endmodule

// ===== src/plcs_finish.sv =====
module plcs_finish (
    input  logic               aclk,
    input  logic               en,
    input  plcs_pkg::div_t     div_in,
    output plcs_pkg::result_t  result_out
);

    plcs_pkg::result_t          result_reg;
    plcs_pkg::result_t          result_next;
    logic [plcs_pkg::PIX_W-1:0] quot;

    always_comb begin
        // work now holds the full quotient
        quot = div_in.side.neg ? (~div_in.work + 1'b1) : div_in.work;
        result_next.pixel_out  = div_in.side.offset + quot;
        result_next.segment    = div_in.side.segment;
        result_next.degenerate = div_in.side.degenerate;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg <= result_next;
        end
    end

    assign result_out = result_reg;

endmodule

// ===== src/piecewise_linear_contrast_stretch_top.sv =====
// channel   direction  ports                                     handshake
// input     in         s_pixel_in                                s_valid / s_ready
// result    out        m_pixel_out, m_segment, m_degenerate      m_valid / m_ready
// config    in         cfg_index, cfg_data                       cfg_wr_en, no wait
//
// one pixel per clock sustained while m_ready stays high; stages: setup, multiply, four
// divide stages at two quotient bits each, then offset and output register.
// aresetn (synchronous) clears all stage valid bits and loads the register defaults.
// each stage holds its word while the next one is full and stalled, so bubbles
// are squeezed out and s_ready drops only when every stage holds a word.
`include "piecewise_linear_contrast_stretch_top_defines.svh"

module piecewise_linear_contrast_stretch_top (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [plcs_pkg::PIX_W-1:0]    s_pixel_in,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [plcs_pkg::PIX_W-1:0]    m_pixel_out,
    output logic [plcs_pkg::SEG_W-1:0]    m_segment,
    output logic                          m_degenerate,

    input  logic                          cfg_wr_en,
    input  logic [plcs_pkg::IDX_W-1:0]    cfg_index,
    input  logic [plcs_pkg::PIX_W-1:0]    cfg_data
);

    localparam int NUM_DIV    = plcs_pkg::PIX_W / plcs_pkg::DIV_BITS_PER_STAGE;
    localparam int NUM_STAGES = NUM_DIV + 3;
    localparam int LAST       = NUM_STAGES - 1;

    plcs_pkg::cfg_t      cfg_reg;
    plcs_pkg::cfg_t      cfg_next;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] stage_en;

    plcs_pkg::setup_t    setup_bus;
    plcs_pkg::div_t      div_bus [0:NUM_DIV];
    plcs_pkg::result_t   result_bus;

    // configuration
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                plcs_pkg::REG_LOW_BREAK:  cfg_next.low_break  = cfg_data;
                plcs_pkg::REG_HIGH_BREAK: cfg_next.high_break = cfg_data;
                plcs_pkg::REG_LOW_LEVEL:  cfg_next.low_level  = cfg_data;
                plcs_pkg::REG_HIGH_LEVEL: cfg_next.high_level = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_break  <= plcs_pkg::RST_LOW_BREAK;
            cfg_reg.high_break <= plcs_pkg::RST_HIGH_BREAK;
            cfg_reg.low_level  <= plcs_pkg::RST_LOW_LEVEL;
            cfg_reg.high_level <= plcs_pkg::RST_HIGH_LEVEL;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // a stage loads when it is empty or its word moves on
    always_comb begin
        stage_en[LAST] = !valid_reg[LAST] || m_ready;
        for (int i = LAST - 1; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
        valid_next[0] = stage_en[0] ? s_valid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            valid_next[i] = stage_en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    plcs_setup u_setup (
        .aclk      (aclk),
        .en        (stage_en[0]),
        .pixel_in  (s_pixel_in),
        .cfg       (cfg_reg),
        .setup_out (setup_bus)
    );

    plcs_mult u_mult (
        .aclk     (aclk),
        .en       (stage_en[1]),
        .setup_in (setup_bus),
        .div_out  (div_bus[0])
    );

    for (genvar k = 0; k < NUM_DIV; k++) begin : g_div
        plcs_div_step u_div_step (
            .aclk    (aclk),
            .en      (stage_en[k+2]),
            .div_in  (div_bus[k]),
            .div_out (div_bus[k+1])
        );
    end

    plcs_finish u_finish (
        .aclk       (aclk),
        .en         (stage_en[LAST]),
        .div_in     (div_bus[NUM_DIV]),
        .result_out (result_bus)
    );

    assign s_ready      = stage_en[0];
    assign m_valid      = valid_reg[LAST];
    assign m_pixel_out  = result_bus.pixel_out;
    assign m_segment    = result_bus.segment;
    assign m_degenerate = result_bus.degenerate;

    // input stalls only with every stage full
    `PLCS_ASSERT_IMPLY(a_stall_full, aclk, aresetn, !s_ready, &valid_reg)
    // an accepted word shows up in the setup stage
    `PLCS_ASSERT_NEXT(a_accept_lands, aclk, aresetn, s_valid && s_ready, valid_reg[0])
    // flagged results always come from the middle segment
    `PLCS_ASSERT_IMPLY(a_degen_mid, aclk, aresetn, m_valid && m_degenerate,
        m_segment == plcs_pkg::SEG_MID)

endmodule

// ===== tb/sv/stretch_compare.sv =====
`timescale 1ns / 1ps

module stretch_compare
    import plcs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [PIX_W-1:0]    s_pixel_in,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [PIX_W-1:0]    m_pixel_out,
    input  logic [SEG_W-1:0]    m_segment,
    input  logic                m_degenerate,
    input  logic                cfg_wr_en,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [PIX_W-1:0]    cfg_data,
    output int                  pending,
    output int                  mismatches
);

    cfg_t    curve;
    result_t expected_pixels[$];
    int      bad_count = 0;
    int      out_count = 0;

    function automatic result_t stretch_pixel(input cfg_t c, input logic [PIX_W-1:0] p);
        int      pv;
        int      a;
        int      b;
        int      lo;
        int      hi;
        int      top;
        int      r;
        result_t res;
        pv  = p;
        a   = c.low_break;
        b   = c.high_break;
        lo  = c.low_level;
        hi  = c.high_level;
        top = PIX_MAX;
        res.degenerate = 1'b0;
        // tests run in this order, so crossed breakpoints never reach the middle
        if (pv < a) begin
            r = (pv * lo) / a;
            res.segment = SEG_LOW;
        end else if (pv > b) begin
            r = ((pv - b) * (top - hi)) / (top - b) + hi;
            res.segment = SEG_HIGH;
        end else if (a == b) begin
            r = lo;
            res.segment = SEG_MID;
            res.degenerate = 1'b1;
        end else begin
            // signed divide truncates toward zero on a falling middle segment
            r = ((pv - a) * (hi - lo)) / (b - a) + lo;
            res.segment = SEG_MID;
        end
        res.pixel_out = r[PIX_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("stretch_compare: word %0d %s got %0d want %0d", out_count, what, got, want);
        bad_count++;
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            curve.low_break  = RST_LOW_BREAK;
            curve.high_break = RST_HIGH_BREAK;
            curve.low_level  = RST_LOW_LEVEL;
            curve.high_level = RST_HIGH_LEVEL;
            expected_pixels.delete();
        end else begin
            if (s_valid && s_ready)
                expected_pixels.push_back(stretch_pixel(curve, s_pixel_in));
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("with nothing expected, pixel_out", m_pixel_out, -1);
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_pixel_out !== want.pixel_out)
                        report_mismatch("pixel_out", m_pixel_out, want.pixel_out);
                    if (m_segment !== want.segment)
                        report_mismatch("segment", m_segment, want.segment);
                    if (m_degenerate !== want.degenerate)
                        report_mismatch("degenerate", m_degenerate, want.degenerate);
                end
                out_count++;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_LOW_BREAK:  curve.low_break  = cfg_data;
                    REG_HIGH_BREAK: curve.high_break = cfg_data;
                    REG_LOW_LEVEL:  curve.low_level  = cfg_data;
                    REG_HIGH_LEVEL: curve.high_level = cfg_data;
                    default: ;
                endcase
            end
        end
        pending    <= expected_pixels.size();
        mismatches <= bad_count;
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import plcs_pkg::*;

    localparam int PHASES     = 13;
    localparam int PHASE_LEN  = 100;
    localparam int HOLD_AFTER = 150;
    localparam int HOLD_LEN   = 80;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [PIX_W-1:0]   s_pixel_in = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [PIX_W-1:0]   m_pixel_out;
    logic [SEG_W-1:0]   m_segment;
    logic               m_degenerate;
    logic               cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [PIX_W-1:0]   cfg_data = '0;
    int                 pending;
    int                 mismatches;

    int in_count = 0;
    bit steady   = 1'b0;
    bit held_off = 1'b0;

    piecewise_linear_contrast_stretch_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_in   (s_pixel_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_out  (m_pixel_out),
        .m_segment    (m_segment),
        .m_degenerate (m_degenerate),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    stretch_compare u_stretch_compare (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_in   (s_pixel_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_out  (m_pixel_out),
        .m_segment    (m_segment),
        .m_degenerate (m_degenerate),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pending      (pending),
        .mismatches   (mismatches)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic logic [PIX_W-1:0] pick_level();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return PIX_MAX;
        else
            return PIX_W'($urandom_range(0, 255));
    endfunction

    function automatic cfg_t pick_curve();
        cfg_t c;
        c.low_break  = pick_level();
        c.high_break = pick_level();
        c.low_level  = pick_level();
        c.high_level = pick_level();
        if ($urandom_range(0, 3) == 0)
            c.high_break = c.low_break;
        return c;
    endfunction

    // a quarter of the pixels land on or next to a breakpoint
    function automatic logic [PIX_W-1:0] pick_pixel(input cfg_t c);
        int v;
        if ($urandom_range(0, 3) == 0) begin
            v = $urandom_range(0, 1) ? c.low_break : c.high_break;
            v = v + $urandom_range(0, 2) - 1;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            return v[PIX_W-1:0];
        end
        return PIX_W'($urandom_range(0, 255));
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] p);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_pixel_in <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        in_count++;
    endtask

    // lets the pipeline empty out before the curve changes
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic load_curve(input cfg_t c);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_LOW_BREAK;
        cfg_data  <= c.low_break;
        @(posedge aclk);
        cfg_index <= REG_HIGH_BREAK;
        cfg_data  <= c.high_break;
        @(posedge aclk);
        cfg_index <= REG_LOW_LEVEL;
        cfg_data  <= c.low_level;
        @(posedge aclk);
        cfg_index <= REG_HIGH_LEVEL;
        cfg_data  <= c.high_level;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_list(input cfg_t c, input int n, input logic [PIX_W-1:0] pix [0:8]);
        drain();
        load_curve(c);
        for (int i = 0; i < n; i++)
            send_pixel(pix[i]);
    endtask

    // receiver: random stalls, one long hold-off once the stream is going
    initial begin
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held_off && in_count >= HOLD_AFTER) begin
                m_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
                held_off = 1'b1;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(50, 200)) @(posedge aclk);
                else
                    repeat ($urandom_range(1, 12)) @(posedge aclk);
                gap = pick_gap();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    initial begin
        logic [PIX_W-1:0] pix [0:8];
        cfg_t             c;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset curve: ends, breakpoints and their neighbors
        pix = '{8'd0, 8'd255, 8'd63, 8'd64, 8'd65, 8'd191, 8'd192, 8'd193, 8'd128};
        for (int i = 0; i < 9; i++)
            send_pixel(pix[i]);

        // falling middle segment
        c = '{8'd40, 8'd200, 8'd230, 8'd20};
        pix = '{8'd40, 8'd120, 8'd200, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        run_list(c, 3, pix);

        // equal breakpoints, hit exactly and missed on each side
        c = '{8'd100, 8'd100, 8'd60, 8'd180};
        pix = '{8'd99, 8'd100, 8'd101, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        run_list(c, 3, pix);

        // crossed breakpoints skip the middle
        c = '{8'd200, 8'd50, 8'd90, 8'd150};
        pix = '{8'd49, 8'd50, 8'd120, 8'd201, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        run_list(c, 4, pix);

        // both breakpoints at zero
        c = '{8'd0, 8'd0, 8'd0, 8'd255};
        pix = '{8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        run_list(c, 2, pix);

        // both breakpoints at full scale
        c = '{8'd255, 8'd255, 8'd255, 8'd0};
        pix = '{8'd0, 8'd254, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        run_list(c, 3, pix);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            c = pick_curve();
            load_curve(c);
            steady = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_LEN; i++)
                send_pixel(pick_pixel(c));
        end

        drain();
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/plcs_pkg.sv
src/plcs_setup.sv
src/plcs_mult.sv
src/plcs_div_step.sv
src/plcs_finish.sv
src/piecewise_linear_contrast_stretch_top.sv
tb/sv/stretch_compare.sv
tb/sv/tb.sv
